>>> sv/bpr_pkg.sv
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants for the beeper edge to PWM resampler: the
// controller states, the command and status groups between controller and
// datapath, register indexes and the averaging table.
// ----------------------------------------------------------------------------
package bpr_pkg;

    // Field widths fixed by the item and register formats.
    localparam int TIME_W   = 15;
    localparam int COUNT_W  = 16;
    localparam int CPS_W    = 3;
    localparam int CPF_W    = 15;
    localparam int VOL_W    = 16;
    localparam int LEVEL_W  = 16;
    localparam int ENTRY_W  = 16;
    localparam int AVG_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Operation codes of an input beat.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_SAMPLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_FRAME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME            = 2'd2;

    // Register reset values.
    localparam logic [CPS_W-1:0] CPS_RESET = 3'd7;
    localparam logic [CPF_W-1:0] CPF_RESET = 15'd4368;
    localparam logic [VOL_W-1:0] VOL_RESET = 16'd4;

    // Averaged level floor(floor(high * 255 / cps) / 4), indexed [cps][high].
    // A zero window gives a zero level.
    localparam logic [AVG_W-1:0] AVG_LUT [8][8] = '{
        '{9'd0, 9'd0,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd0, 9'd63, 9'd127, 9'd191, 9'd255, 9'd318, 9'd382, 9'd446},
        '{9'd0, 9'd31, 9'd63,  9'd95,  9'd127, 9'd159, 9'd191, 9'd223},
        '{9'd0, 9'd21, 9'd42,  9'd63,  9'd85,  9'd106, 9'd127, 9'd148},
        '{9'd0, 9'd15, 9'd31,  9'd47,  9'd63,  9'd79,  9'd95,  9'd111},
        '{9'd0, 9'd12, 9'd25,  9'd38,  9'd51,  9'd63,  9'd76,  9'd89},
        '{9'd0, 9'd10, 9'd21,  9'd31,  9'd42,  9'd53,  9'd63,  9'd74},
        '{9'd0, 9'd9,  9'd18,  9'd27,  9'd36,  9'd45,  9'd54,  9'd63}
    };

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_POP,
        ST_TAIL,
        ST_SCALE,
        ST_MUL,
        ST_SW_RD,
        ST_SW_WR,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic edge_write;
        logic tick_start;
        logic rd_issue;
        logic pop;
        logic tail;
        logic scale;
        logic mul_frame;
        logic sw_start;
        logic sw_rd;
        logic sw_wr;
        logic out_load;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic queue_empty;
        logic edge_late;
        logic sweep_needed;
        logic sweep_last;
    } t_dp_sts;

endpackage

>>> sv/bpr_ctrl.sv
// ----------------------------------------------------------------------------
// bpr_ctrl
// Sequencer for the resampler: accepts beats, steps the datapath through the
// edge pops, scaling, frame rebase sweep and result hand-off.
// ----------------------------------------------------------------------------
module bpr_ctrl
    import bpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_operation,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // The output register can be loaded when empty or being taken this edge.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_operation == OP_TICK) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = i_sts.queue_empty ? ST_TAIL : ST_POP;
            end
            ST_POP: begin
                n_state = i_sts.edge_late ? ST_TAIL : ST_READ;
            end
            ST_TAIL:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_MUL;
            ST_MUL: begin
                n_state = i_sts.sweep_needed ? ST_SW_RD : ST_EMIT;
            end
            ST_SW_RD: n_state = ST_SW_WR;
            ST_SW_WR: begin
                n_state = i_sts.sweep_last ? ST_EMIT : ST_SW_RD;
            end
            ST_EMIT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.edge_write = i_in_valid && i_operation == OP_EDGE;
                o_cmd.tick_start = i_in_valid && i_operation == OP_TICK;
            end
            ST_READ: o_cmd.rd_issue = !i_sts.queue_empty;
            ST_POP:  o_cmd.pop = !i_sts.edge_late;
            ST_TAIL: o_cmd.tail = 1'b1;
            ST_SCALE: o_cmd.scale = 1'b1;
            ST_MUL: begin
                o_cmd.mul_frame = 1'b1;
                o_cmd.sw_start  = i_sts.sweep_needed;
            end
            ST_SW_RD: o_cmd.sw_rd = 1'b1;
            ST_SW_WR: o_cmd.sw_wr = 1'b1;
            ST_EMIT: o_cmd.out_load = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/bpr_datapath.sv
// ----------------------------------------------------------------------------
// bpr_datapath
// Edge queue memory, cycle counter, window accumulation, level scaling,
// frame rebase sweep, configuration registers and output payload registers.
// ----------------------------------------------------------------------------
module bpr_datapath
    import bpr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [TIME_W-1:0]     i_edge_time,
    input  logic                  i_edge_level,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic [LEVEL_W-1:0]    o_pwm_level,
    output logic                  o_frame_end
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Configuration registers.
    logic [CPS_W-1:0] r_cps;
    logic [CPF_W-1:0] r_cpf;
    logic [VOL_W-1:0] r_volume;

    // Control state.
    logic [COUNT_W-1:0] r_cycle_count, n_cycle_count;
    logic               r_last_level, n_last_level;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]   r_fill, n_fill;

    // Working registers of one tick.
    logic [CPS_W-1:0]   r_pos, n_pos;
    logic [CPS_W-1:0]   r_high, n_high;
    logic [AVG_W-1:0]   r_avg;
    logic [LEVEL_W-1:0] r_level;
    logic               r_frame;
    logic [PTR_W-1:0]   r_sw_ptr, n_sw_ptr;
    logic [CNT_W-1:0]   r_sw_cnt, n_sw_cnt;

    // Queue memory and its registered read data.
    logic [ENTRY_W-1:0] r_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               w_mem_we;
    logic [PTR_W-1:0]   w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic               w_mem_re;
    logic [PTR_W-1:0]   w_rd_addr;

    logic                 w_full;
    logic [TIME_W-1:0]    w_entry_time;
    logic                 w_entry_level;
    logic [COUNT_W-1:0]   w_dist;
    logic signed [17:0]   w_offset;
    logic                 w_advance;
    logic [CPS_W-1:0]     w_step;
    logic                 w_frame_hit;
    logic                 w_rebase_entry;
    logic [24:0]          w_prod;

    assign w_full        = (r_fill == CNT_FULL);
    assign w_entry_time  = r_rd_data[TIME_W-1:0];
    assign w_entry_level = r_rd_data[ENTRY_W-1];

    // Distance of the edge before the window end, and its offset from start.
    assign w_dist    = r_cycle_count - {1'b0, w_entry_time};
    assign w_offset  = $signed({15'b0, r_cps}) - $signed({2'b0, w_dist});
    assign w_advance = w_offset > $signed({15'b0, r_pos});
    assign w_step    = w_offset[CPS_W-1:0] - r_pos;

    assign w_frame_hit    = r_cycle_count >= {1'b0, r_cpf};
    assign w_rebase_entry = w_entry_time >= r_cpf;
    assign w_prod         = r_avg * r_volume;

    // Status toward the controller.
    assign o_sts.queue_empty  = (r_fill == '0);
    assign o_sts.edge_late    = {1'b0, w_entry_time} > r_cycle_count;
    assign o_sts.sweep_needed = w_frame_hit && (r_fill != '0) && (r_cpf != '0);
    assign o_sts.sweep_last   = (r_sw_cnt + CNT_W'(1)) == r_fill;

    // Memory port selection: edges and sweep write-backs share the write port.
    always_comb begin
        w_mem_we  = 1'b0;
        w_wr_addr = r_wr_ptr;
        w_wr_data = {i_edge_level, i_edge_time};
        if (i_cmd.edge_write && !w_full) begin
            w_mem_we = 1'b1;
        end else if (i_cmd.sw_wr && w_rebase_entry) begin
            w_mem_we  = 1'b1;
            w_wr_addr = r_sw_ptr;
            w_wr_data = r_rd_data - {1'b0, r_cpf};
        end
        w_mem_re  = i_cmd.rd_issue || i_cmd.sw_rd;
        w_rd_addr = i_cmd.sw_rd ? r_sw_ptr : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Next values of the queue state and the window accumulation.
    always_comb begin
        n_cycle_count = r_cycle_count;
        n_last_level  = r_last_level;
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_fill        = r_fill;
        n_pos         = r_pos;
        n_high        = r_high;
        n_sw_ptr      = r_sw_ptr;
        n_sw_cnt      = r_sw_cnt;

        if (i_cmd.edge_write && !w_full) begin
            n_wr_ptr = next_ptr(r_wr_ptr);
            n_fill   = r_fill + CNT_W'(1);
        end

        if (i_cmd.tick_start) begin
            n_cycle_count = r_cycle_count + {13'b0, r_cps};
            n_pos         = '0;
            n_high        = '0;
        end

        // Consume one edge at or before the window end.
        if (i_cmd.pop) begin
            if (w_advance) begin
                if (r_last_level) n_high = r_high + w_step;
                n_pos = w_offset[CPS_W-1:0];
            end
            n_last_level = w_entry_level;
            n_rd_ptr     = next_ptr(r_rd_ptr);
            n_fill       = r_fill - CNT_W'(1);
        end

        // Level held from the last edge to the window end.
        if (i_cmd.tail && r_cps > r_pos && r_last_level) begin
            n_high = r_high + (r_cps - r_pos);
        end

        if (i_cmd.mul_frame && w_frame_hit) begin
            n_cycle_count = r_cycle_count - {1'b0, r_cpf};
        end

        if (i_cmd.sw_start) begin
            n_sw_ptr = r_rd_ptr;
            n_sw_cnt = '0;
        end
        if (i_cmd.sw_wr) begin
            n_sw_ptr = next_ptr(r_sw_ptr);
            n_sw_cnt = r_sw_cnt + CNT_W'(1);
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_count <= '0;
            r_last_level  <= 1'b0;
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_fill        <= '0;
        end else begin
            r_cycle_count <= n_cycle_count;
            r_last_level  <= n_last_level;
            r_rd_ptr      <= n_rd_ptr;
            r_wr_ptr      <= n_wr_ptr;
            r_fill        <= n_fill;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cps    <= CPS_RESET;
            r_cpf    <= CPF_RESET;
            r_volume <= VOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CYCLES_PER_SAMPLE: r_cps    <= i_cfg_data[CPS_W-1:0];
                CFG_CYCLES_PER_FRAME:  r_cpf    <= i_cfg_data[CPF_W-1:0];
                CFG_VOLUME:            r_volume <= i_cfg_data[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_high   <= n_high;
        r_sw_ptr <= n_sw_ptr;
        r_sw_cnt <= n_sw_cnt;
        if (i_cmd.scale) begin
            r_avg <= AVG_LUT[r_cps][r_high];
        end
        if (i_cmd.mul_frame) begin
            r_level <= w_prod[LEVEL_W-1:0];
            r_frame <= w_frame_hit;
        end
        if (i_cmd.out_load) begin
            o_pwm_level <= r_level;
            o_frame_end <= r_frame;
        end
    end

endmodule

>>> sv/beeper_edge_to_pwm_resampler_top.sv
// ----------------------------------------------------------------------------
// beeper_edge_to_pwm_resampler_top
// Queues timestamped speaker edges and turns each sample tick into one
// scaled PWM level, with frame rebasing of the cycle count and queue.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_stall   i_operation, i_edge_time,
//                                                i_edge_level
//  out      output     o_out_valid / i_out_stall o_pwm_level, o_frame_end
//  cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// An edge beat is taken while idle. Each edge a tick pops takes a read state for
// the registered queue memory read and a pop state; a queued edge beyond the
// window end stops the pops. Tail, scale and multiply steps follow; a tick that
// ends a frame then sweeps the edges left, rebasing those past the frame end.
// Reset needs no clearing pass; queue entries are only read once written.
// Input stalls while a tick is in progress; a finished result waits in the
// output register while the next beat can already be taken.
// ----------------------------------------------------------------------------
module beeper_edge_to_pwm_resampler_top
    import bpr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [TIME_W-1:0]     i_edge_time,
    input  logic                  i_edge_level,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [LEVEL_W-1:0]    o_pwm_level,
    output logic                  o_frame_end
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    bpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Queue, arithmetic and registers.
    bpr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_edge_time  (i_edge_time),
        .i_edge_level (i_edge_level),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_pwm_level  (o_pwm_level),
        .o_frame_end  (o_frame_end)
    );

endmodule
